// ===== hdl/fsf_pkg.sv =====
// ----------------------------------------------------------------------------
// Four-level feedback scheduler package
// Shared transaction types, command and status codes, and the command and
// status structures that join the controller and the datapath.
// ----------------------------------------------------------------------------
package fsf_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_MAX_JOBS    = 256;

    localparam logic [15:0] QUANTUM_RESET = 16'd100;
    localparam logic [15:0] AGING_RESET   = 16'd1000;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGING   = 1'b1;

    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_AGE      = 2'd1;
    localparam logic [1:0] CMD_DISPATCH = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;
    localparam logic [1:0] STATUS_BAD   = 2'd3;

    localparam int ITEM_W = 24;

    // Datapath micro-operations.
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
    localparam logic [OP_W-1:0] OP_LATCH    = 5'd1;
    localparam logic [OP_W-1:0] OP_RD_HEAD  = 5'd2;
    localparam logic [OP_W-1:0] OP_TAKE     = 5'd3;
    localparam logic [OP_W-1:0] OP_PICK     = 5'd4;
    localparam logic [OP_W-1:0] OP_FULL     = 5'd5;
    localparam logic [OP_W-1:0] OP_BADLVL   = 5'd6;
    localparam logic [OP_W-1:0] OP_EMPTY    = 5'd7;
    localparam logic [OP_W-1:0] OP_FPUSH    = 5'd8;
    localparam logic [OP_W-1:0] OP_FDROP    = 5'd9;
    localparam logic [OP_W-1:0] OP_HP_INIT  = 5'd10;
    localparam logic [OP_W-1:0] OP_HP_RDPAR = 5'd11;
    localparam logic [OP_W-1:0] OP_HP_PUT   = 5'd12;
    localparam logic [OP_W-1:0] OP_HP_UP    = 5'd13;
    localparam logic [OP_W-1:0] OP_HD_INIT  = 5'd14;
    localparam logic [OP_W-1:0] OP_HD_LAST  = 5'd15;
    localparam logic [OP_W-1:0] OP_HD_RDL   = 5'd16;
    localparam logic [OP_W-1:0] OP_HD_CMPL  = 5'd17;
    localparam logic [OP_W-1:0] OP_HD_STEP  = 5'd18;
    localparam logic [OP_W-1:0] OP_STAMP    = 5'd19;
    localparam logic [OP_W-1:0] OP_OUT      = 5'd20;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  job_id;
        logic [2:0]  start_level;
        logic [15:0] burst_ms;
        logic [31:0] now_ms;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  picked_id;
        logic [2:0]  picked_level;
        logic [15:0] granted_ms;
        logic        finishes;
        logic [2:0]  promoted_mask;
    } out_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [1:0]      q;
        logic            set_mask;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] start_level;
        logic [3:0] empty;
        logic [3:0] full;
        logic       aged;
        logic       idx_zero;
        logic       par_le;
        logic       has_l;
        logic       hd_stop;
        logic       fin;
        logic       out_free;
    } ctl_stat_t;

endpackage

// ===== hdl/fsf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fsf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/fsf_datapath.sv =====
// ----------------------------------------------------------------------------
// Scheduler datapath
// Queue storage, entry time stamps, counters, heap sift registers and the
// result register, all driven by micro-operations from the controller.
// ----------------------------------------------------------------------------
module fsf_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_JOBS    = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fsf_pkg::in_t               s_data,
    output fsf_pkg::out_t              m_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    input  logic                       cfg_we,
    input  logic [fsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                cfg_wdata,
    input  fsf_pkg::ctl_cmd_t          cmd,
    output fsf_pkg::ctl_stat_t         stat
);
    import fsf_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int XW = QW + 2;
    localparam int JW = $clog2(MAX_JOBS);
    localparam int AW = QW + 2;

    localparam logic [CW-1:0]   CNT_FULL = CW'(QUEUE_DEPTH);
    localparam logic [QW:0]     DEPTH_X  = (QW+1)'(QUEUE_DEPTH);
    localparam logic [QW-1:0]   PTR_LAST = QW'(QUEUE_DEPTH - 1);

    logic [CW-1:0]     cnt_reg [4];
    logic [CW-1:0]     cnt_next [4];
    logic [QW-1:0]     rptr_top_reg, rptr_top_next;
    logic [QW-1:0]     rptr_bot_reg, rptr_bot_next;
    in_t               in_reg, in_next;
    logic [ITEM_W-1:0] item_reg, item_next;
    logic [ITEM_W-1:0] best_reg, best_next;
    logic [QW-1:0]     idx_reg, idx_next;
    logic [QW-1:0]     bidx_reg, bidx_next;
    logic [CW-1:0]     lim_reg, lim_next;
    logic [7:0]        id_reg, id_next;
    logic [1:0]        status_reg, status_next;
    logic [2:0]        mask_reg, mask_next;
    logic [7:0]        pid_reg, pid_next;
    logic [2:0]        plv_reg, plv_next;
    logic [15:0]       grant_reg, grant_next;
    logic              fin_reg, fin_next;
    logic [15:0]       quantum_reg, quantum_next;
    logic [15:0]       aging_reg, aging_next;
    out_t              m_data_reg, m_data_next;
    logic              m_valid_reg, m_valid_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [ITEM_W-1:0] ram_wdata, ram_rd;
    logic              et_we;
    logic [31:0]       et_rd;
    logic [JW-1:0]     mod_tab [256];

    logic [QW-1:0]     head_ptr;
    logic [QW:0]       tail_sum;
    logic [QW-1:0]     tail_ptr;
    logic [QW-1:0]     parent;
    logic [XW-1:0]     l_idx, r_idx, lim_x;
    logic              r_ok, r_less;
    logic [QW-1:0]     cand;
    logic [ITEM_W-1:0] cand_val;
    logic [31:0]       age_d;
    logic [15:0]       burst;
    logic              clip;
    logic [15:0]       grant_val;

    // Job id to stamp slot, reduced modulo the number of slots.
    for (genvar k = 0; k < 256; k++) begin : g_mod
        assign mod_tab[k] = JW'(k % MAX_JOBS);
    end

    fsf_ram #(.WIDTH(ITEM_W), .DEPTH(4 << QW)) u_queue_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rd)
    );

    fsf_ram #(.WIDTH(32), .DEPTH(MAX_JOBS)) u_stamp_ram (
        .aclk  (aclk),
        .we    (et_we),
        .waddr (mod_tab[id_reg]),
        .wdata (in_reg.now_ms),
        .raddr (mod_tab[ram_rd[7:0]]),
        .rdata (et_rd)
    );

    always_comb begin
        head_ptr = (cmd.q == 2'd3) ? rptr_bot_reg : rptr_top_reg;
        tail_sum = (QW+1)'(head_ptr) + (QW+1)'(cnt_reg[cmd.q]);
        tail_ptr = (tail_sum >= DEPTH_X) ? QW'(tail_sum - DEPTH_X) : tail_sum[QW-1:0];
        parent   = QW'((idx_reg - QW'(1)) >> 1);
        l_idx    = {1'b0, idx_reg, 1'b1};
        r_idx    = l_idx + XW'(1);
        lim_x    = XW'(lim_reg);
        r_ok     = r_idx < lim_x;
        r_less   = r_ok && (ram_rd < best_reg);
        cand     = r_less ? r_idx[QW-1:0] : bidx_reg;
        cand_val = r_less ? ram_rd : best_reg;
        age_d    = in_reg.now_ms - et_rd;
        burst    = item_reg[23:8];
        clip     = (cmd.q == 2'd0) && (quantum_reg < burst);
        grant_val = clip ? quantum_reg : burst;
    end

    always_comb begin
        stat.command     = in_reg.command;
        stat.start_level = in_reg.start_level;
        for (int i = 0; i < 4; i++) begin
            stat.empty[i] = (cnt_reg[i] == '0);
            stat.full[i]  = (cnt_reg[i] >= CNT_FULL);
        end
        stat.aged     = !age_d[31] && (age_d > {16'd0, aging_reg});
        stat.idx_zero = (idx_reg == '0);
        stat.par_le   = (ram_rd <= item_reg);
        stat.has_l    = l_idx < lim_x;
        stat.hd_stop  = (cand == idx_reg);
        stat.fin      = fin_reg;
        stat.out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            cnt_next[i] = cnt_reg[i];
        end
        rptr_top_next = rptr_top_reg;
        rptr_bot_next = rptr_bot_reg;
        in_next       = in_reg;
        item_next     = item_reg;
        best_next     = best_reg;
        idx_next      = idx_reg;
        bidx_next     = bidx_reg;
        lim_next      = lim_reg;
        id_next       = id_reg;
        status_next   = status_reg;
        mask_next     = mask_reg;
        pid_next      = pid_reg;
        plv_next      = plv_reg;
        grant_next    = grant_reg;
        fin_next      = fin_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        ram_we        = 1'b0;
        ram_waddr     = {cmd.q, idx_reg};
        ram_wdata     = item_reg;
        ram_raddr     = {cmd.q, QW'(0)};
        et_we         = 1'b0;

        quantum_next = quantum_reg;
        aging_next   = aging_reg;
        if (cfg_we) begin
            if (cfg_index == CFG_QUANTUM) begin
                quantum_next = cfg_wdata;
            end else begin
                aging_next = cfg_wdata;
            end
        end

        case (cmd.op)
            OP_LATCH: begin
                in_next     = s_data;
                id_next     = s_data.job_id;
                item_next   = {s_data.burst_ms, s_data.job_id};
                status_next = STATUS_OK;
                mask_next   = '0;
                pid_next    = '0;
                plv_next    = '0;
                grant_next  = '0;
                fin_next    = 1'b0;
            end
            OP_RD_HEAD: begin
                if (cmd.q == 2'd0 || cmd.q == 2'd3) begin
                    ram_raddr = {cmd.q, head_ptr};
                end
            end
            OP_TAKE: begin
                item_next = ram_rd;
                id_next   = ram_rd[7:0];
            end
            OP_PICK: begin
                pid_next   = item_reg[7:0];
                plv_next   = {1'b0, cmd.q} + 3'd1;
                grant_next = grant_val;
                fin_next   = !clip;
                item_next  = {burst - grant_val, item_reg[7:0]};
            end
            OP_FULL:   status_next = STATUS_FULL;
            OP_BADLVL: status_next = STATUS_BAD;
            OP_EMPTY:  status_next = STATUS_EMPTY;
            OP_FPUSH: begin
                ram_we          = 1'b1;
                ram_waddr       = {cmd.q, tail_ptr};
                cnt_next[cmd.q] = cnt_reg[cmd.q] + CW'(1);
            end
            OP_FDROP: begin
                if (cmd.q == 2'd3) begin
                    rptr_bot_next = (rptr_bot_reg == PTR_LAST) ? '0 : rptr_bot_reg + QW'(1);
                end else begin
                    rptr_top_next = (rptr_top_reg == PTR_LAST) ? '0 : rptr_top_reg + QW'(1);
                end
                cnt_next[cmd.q] = cnt_reg[cmd.q] - CW'(1);
            end
            OP_HP_INIT: begin
                idx_next        = cnt_reg[cmd.q][QW-1:0];
                cnt_next[cmd.q] = cnt_reg[cmd.q] + CW'(1);
            end
            OP_HP_RDPAR: ram_raddr = {cmd.q, parent};
            OP_HP_PUT: ram_we = 1'b1;
            OP_HP_UP: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rd;
                idx_next  = parent;
            end
            OP_HD_INIT: begin
                cnt_next[cmd.q] = cnt_reg[cmd.q] - CW'(1);
                lim_next        = cnt_reg[cmd.q] - CW'(1);
                ram_raddr       = {cmd.q, QW'(cnt_reg[cmd.q] - CW'(1))};
            end
            OP_HD_LAST: begin
                item_next = ram_rd;
                idx_next  = '0;
            end
            OP_HD_RDL: ram_raddr = {cmd.q, l_idx[QW-1:0]};
            OP_HD_CMPL: begin
                if (ram_rd < item_reg) begin
                    best_next = ram_rd;
                    bidx_next = l_idx[QW-1:0];
                end else begin
                    best_next = item_reg;
                    bidx_next = idx_reg;
                end
                ram_raddr = {cmd.q, r_idx[QW-1:0]};
            end
            OP_HD_STEP: begin
                ram_we = 1'b1;
                if (cand != idx_reg) begin
                    ram_wdata = cand_val;
                    idx_next  = cand;
                end
            end
            OP_STAMP: begin
                et_we = 1'b1;
                if (cmd.set_mask) begin
                    mask_next[cmd.q - 2'd1] = 1'b1;
                end
            end
            OP_OUT: begin
                m_data_next.status        = status_reg;
                m_data_next.picked_id     = pid_reg;
                m_data_next.picked_level  = plv_reg;
                m_data_next.granted_ms    = grant_reg;
                m_data_next.finishes      = fin_reg;
                m_data_next.promoted_mask = mask_reg;
                m_valid_next              = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                cnt_reg[i] <= '0;
            end
            rptr_top_reg <= '0;
            rptr_bot_reg <= '0;
            m_valid_reg  <= 1'b0;
            quantum_reg  <= QUANTUM_RESET;
            aging_reg    <= AGING_RESET;
        end else begin
            for (int i = 0; i < 4; i++) begin
                cnt_reg[i] <= cnt_next[i];
            end
            rptr_top_reg <= rptr_top_next;
            rptr_bot_reg <= rptr_bot_next;
            m_valid_reg  <= m_valid_next;
            quantum_reg  <= quantum_next;
            aging_reg    <= aging_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        item_reg   <= item_next;
        best_reg   <= best_next;
        idx_reg    <= idx_next;
        bidx_reg   <= bidx_next;
        lim_reg    <= lim_next;
        id_reg     <= id_next;
        status_reg <= status_next;
        mask_reg   <= mask_next;
        pid_reg    <= pid_next;
        plv_reg    <= plv_next;
        grant_reg  <= grant_next;
        fin_reg    <= fin_next;
        m_data_reg <= m_data_next;
    end

    assign m_data  = m_data_reg;
    assign m_valid = m_valid_reg;

endmodule

// ===== hdl/fsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences each command as a series of datapath micro-operations, including
// the heap sift-up and sift-down loops.
// ----------------------------------------------------------------------------
module fsf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fsf_pkg::ctl_stat_t  stat,
    output fsf_pkg::ctl_cmd_t   cmd
);
    import fsf_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DECODE  = 5'd1;
    localparam logic [4:0] S_PUSH    = 5'd2;
    localparam logic [4:0] S_HP_CHK  = 5'd3;
    localparam logic [4:0] S_HP_CMP  = 5'd4;
    localparam logic [4:0] S_PUSHED  = 5'd5;
    localparam logic [4:0] S_DROP    = 5'd6;
    localparam logic [4:0] S_HD_LAST = 5'd7;
    localparam logic [4:0] S_HD_L    = 5'd8;
    localparam logic [4:0] S_HD_CMPL = 5'd9;
    localparam logic [4:0] S_HD_STEP = 5'd10;
    localparam logic [4:0] S_DROPPED = 5'd11;
    localparam logic [4:0] S_STAMP   = 5'd12;
    localparam logic [4:0] S_AG_RD   = 5'd13;
    localparam logic [4:0] S_AG_TAKE = 5'd14;
    localparam logic [4:0] S_AG_CHK  = 5'd15;
    localparam logic [4:0] S_D_RD    = 5'd16;
    localparam logic [4:0] S_D_TAKE  = 5'd17;
    localparam logic [4:0] S_D_PICK  = 5'd18;
    localparam logic [4:0] S_D_REQ   = 5'd19;
    localparam logic [4:0] S_FIN     = 5'd20;

    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_AGE  = 2'd1;
    localparam logic [1:0] MODE_DISP = 2'd2;

    logic [4:0] state_reg, state_next;
    logic [1:0] mode_reg, mode_next;
    logic [1:0] src_reg, src_next;
    logic [1:0] q_reg, q_next;
    logic [1:0] lq;
    logic [1:0] tgt;

    always_comb begin
        lq         = 2'(stat.start_level - 3'd1);
        tgt        = src_reg - 2'd1;
        state_next = state_reg;
        mode_next  = mode_reg;
        src_next   = src_reg;
        q_next     = q_reg;
        cmd.op       = OP_NONE;
        cmd.q        = q_reg;
        cmd.set_mask = 1'b0;
        s_ready      = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (stat.command)
                    CMD_ADD: begin
                        mode_next = MODE_ADD;
                        if (stat.start_level inside {[3'd1:3'd4]}) begin
                            q_next = lq;
                            if (stat.full[lq]) begin
                                cmd.op     = OP_FULL;
                                state_next = S_FIN;
                            end else begin
                                state_next = S_PUSH;
                            end
                        end else begin
                            cmd.op     = OP_BADLVL;
                            state_next = S_FIN;
                        end
                    end
                    CMD_AGE: begin
                        mode_next  = MODE_AGE;
                        src_next   = 2'd1;
                        q_next     = 2'd1;
                        state_next = S_AG_RD;
                    end
                    CMD_DISPATCH: begin
                        mode_next = MODE_DISP;
                        if (&stat.empty) begin
                            cmd.op     = OP_EMPTY;
                            state_next = S_FIN;
                        end else begin
                            if (!stat.empty[0]) begin
                                q_next = 2'd0;
                            end else if (!stat.empty[1]) begin
                                q_next = 2'd1;
                            end else if (!stat.empty[2]) begin
                                q_next = 2'd2;
                            end else begin
                                q_next = 2'd3;
                            end
                            state_next = S_D_RD;
                        end
                    end
                    default: begin
                        cmd.op     = OP_BADLVL;
                        state_next = S_FIN;
                    end
                endcase
            end
            S_PUSH: begin
                if (q_reg == 2'd0 || q_reg == 2'd3) begin
                    cmd.op     = OP_FPUSH;
                    state_next = S_PUSHED;
                end else begin
                    cmd.op     = OP_HP_INIT;
                    state_next = S_HP_CHK;
                end
            end
            S_HP_CHK: begin
                if (stat.idx_zero) begin
                    cmd.op     = OP_HP_PUT;
                    state_next = S_PUSHED;
                end else begin
                    cmd.op     = OP_HP_RDPAR;
                    state_next = S_HP_CMP;
                end
            end
            S_HP_CMP: begin
                if (stat.par_le) begin
                    cmd.op     = OP_HP_PUT;
                    state_next = S_PUSHED;
                end else begin
                    cmd.op     = OP_HP_UP;
                    state_next = S_HP_CHK;
                end
            end
            S_PUSHED: begin
                if (mode_reg == MODE_AGE) begin
                    q_next     = src_reg;
                    state_next = S_DROP;
                end else begin
                    state_next = S_STAMP;
                end
            end
            S_DROP: begin
                if (q_reg == 2'd0 || q_reg == 2'd3) begin
                    cmd.op     = OP_FDROP;
                    state_next = S_DROPPED;
                end else begin
                    cmd.op     = OP_HD_INIT;
                    state_next = S_HD_LAST;
                end
            end
            S_HD_LAST: begin
                cmd.op     = OP_HD_LAST;
                state_next = S_HD_L;
            end
            S_HD_L: begin
                if (stat.has_l) begin
                    cmd.op     = OP_HD_RDL;
                    state_next = S_HD_CMPL;
                end else begin
                    cmd.op     = OP_HP_PUT;
                    state_next = S_DROPPED;
                end
            end
            S_HD_CMPL: begin
                cmd.op     = OP_HD_CMPL;
                state_next = S_HD_STEP;
            end
            S_HD_STEP: begin
                cmd.op     = OP_HD_STEP;
                state_next = stat.hd_stop ? S_DROPPED : S_HD_L;
            end
            S_DROPPED: begin
                if (mode_reg == MODE_AGE) begin
                    state_next = S_STAMP;
                end else if (q_reg == 2'd0 && !stat.fin) begin
                    state_next = S_D_REQ;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_STAMP: begin
                cmd.op       = OP_STAMP;
                cmd.set_mask = (mode_reg == MODE_AGE);
                if (mode_reg != MODE_AGE) begin
                    state_next = S_FIN;
                end else if (src_reg == 2'd3) begin
                    state_next = S_FIN;
                end else begin
                    src_next   = src_reg + 2'd1;
                    q_next     = src_reg + 2'd1;
                    state_next = S_AG_RD;
                end
            end
            S_AG_RD: begin
                if (!stat.empty[src_reg]) begin
                    cmd.op     = OP_RD_HEAD;
                    state_next = S_AG_TAKE;
                end else if (src_reg == 2'd3) begin
                    state_next = S_FIN;
                end else begin
                    src_next = src_reg + 2'd1;
                    q_next   = src_reg + 2'd1;
                end
            end
            S_AG_TAKE: begin
                cmd.op     = OP_TAKE;
                state_next = S_AG_CHK;
            end
            S_AG_CHK: begin
                if (stat.aged && !stat.full[tgt]) begin
                    q_next     = tgt;
                    state_next = S_PUSH;
                end else begin
                    if (stat.aged) begin
                        cmd.op = OP_FULL;
                    end
                    if (src_reg == 2'd3) begin
                        state_next = S_FIN;
                    end else begin
                        src_next   = src_reg + 2'd1;
                        q_next     = src_reg + 2'd1;
                        state_next = S_AG_RD;
                    end
                end
            end
            S_D_RD: begin
                cmd.op     = OP_RD_HEAD;
                state_next = S_D_TAKE;
            end
            S_D_TAKE: begin
                cmd.op     = OP_TAKE;
                state_next = S_D_PICK;
            end
            S_D_PICK: begin
                cmd.op     = OP_PICK;
                state_next = S_DROP;
            end
            S_D_REQ: begin
                cmd.op     = OP_FPUSH;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        src_reg  <= src_next;
        q_reg    <= q_next;
    end

endmodule

// ===== hdl/four_level_feedback_scheduler.sv =====
// Each transaction runs as a sequence of micro-operations, with sift steps added for a heap level;
// a result still held by m_ready delays the registering of the next result.
// Throughput: one transaction at a time; the next is accepted once the result is registered.
// Reset: aresetn (synchronous, active low) empties the queues and reloads the configuration.
// ----------------------------------------------------------------------------
// Four-level feedback scheduler
// Keeps two FIFO levels and two min-heap levels of jobs, serves dispatch,
// add and aging transactions, and returns one result transaction for each.
// ----------------------------------------------------------------------------
module four_level_feedback_scheduler #(
    parameter int QUEUE_DEPTH = fsf_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_JOBS    = fsf_pkg::DEF_MAX_JOBS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  fsf_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output fsf_pkg::out_t                 m_data,
    input  logic                          cfg_we,
    input  logic [fsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_wdata
);
    import fsf_pkg::*;

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    // The controller walks each transaction through its micro-operations. The
    // next input transaction is taken as soon as the current result has been
    // loaded into the output register, even if that result is still waiting.
    fsf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds all four levels in one queue memory, the entry time
    // stamps in a second memory, and the registered result.
    fsf_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_JOBS    (MAX_JOBS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

`ifndef SYNTH
    // The controller must leave idle right after taking a transaction.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a transaction was still in progress");

    // A result without a picked job grants nothing.
    a_no_pick_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.picked_level == 3'd0) |->
        (m_data.granted_ms == 16'd0 && !m_data.finishes && m_data.picked_id == 8'd0))
        else $error("grant reported without a picked job");

    // Jobs from the lower three levels always run to completion.
    a_lower_levels_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.picked_level != 3'd0 && m_data.picked_level != 3'd1) |->
        m_data.finishes)
        else $error("lower level job did not finish");

    // Promotions and dispatch never appear in the same result.
    a_mask_only_on_aging: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.promoted_mask != 3'd0) |-> (m_data.picked_level == 3'd0))
        else $error("promotion reported together with a dispatch");
`endif

endmodule
